>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker module of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define RBC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked property that is also checked during reset.
`define RBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> hdl/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Types and constants of the relaxed body canonicalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

  localparam int BreakCountBitsDef = 16;
  localparam int OutBreakBits      = 16;

  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChSp  = 8'h20;

  localparam logic [OutBreakBits-1:0] OutBreakMax = '1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       last_of_body;
  } in_item_t;

  typedef struct packed {
    logic [OutBreakBits-1:0] breaks_before;
    logic                    space_before;
    logic                    cr_before;
    logic [7:0]              out_byte;
    logic                    byte_valid;
    logic                    final_crlf;
    logic                    breaks_clipped;
  } out_item_t;

  // Input stage to core.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

`default_nettype wire

>>> hdl/relaxed_body_canonicalizer.sv
// ----------------------------------------------------------------------------
// relaxed_body_canonicalizer
// Streaming relaxed body canonicalization, one body byte per transaction.
// ----------------------------------------------------------------------------
// One body byte in, one compressed result out, sustained at one transaction
// per cycle unless the output stalls. An input register feeds the decision
// logic writing the result register alongside the held line-break count,
// pending space and held CR. The break counter is BREAK_COUNT_BITS wide and
// saturates; the emitted count is clamped to 16 bits. A transaction with
// tlast closes the body with the final CRLF and returns state to reset.
`default_nettype none

module relaxed_body_canonicalizer #(
  parameter int BREAK_COUNT_BITS = rbc_pkg::BreakCountBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tuser,   // [0] byte_present
  input  wire logic        s_axis_tlast,   // last_of_body
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] breaks_before, [16] space_before,
                                           // [17] cr_before, [25:18] out_byte,
                                           // [26] breaks_clipped, [31:27] zero
  output logic             m_axis_tuser,   // [0] byte_valid
  output logic             m_axis_tlast    // final_crlf
);

  rbc_pkg::in_item_t  s_item;
  rbc_pkg::stage_t    stage;
  rbc_pkg::out_item_t m_item;
  logic               core_ready;

  assign s_item.in_byte      = s_axis_tdata;
  assign s_item.byte_present = s_axis_tuser;
  assign s_item.last_of_body = s_axis_tlast;

  rbc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .stage      (stage),
    .core_ready (core_ready)
  );

  rbc_core #(
    .BREAK_COUNT_BITS (BREAK_COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .core_ready (core_ready),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_item     (m_item)
  );

  assign m_axis_tdata = {5'b0, m_item.breaks_clipped, m_item.out_byte,
                         m_item.cr_before, m_item.space_before,
                         m_item.breaks_before};
  assign m_axis_tuser = m_item.byte_valid;
  assign m_axis_tlast = m_item.final_crlf;

endmodule

`default_nettype wire

>>> hdl/rbc_in_reg.sv
// ----------------------------------------------------------------------------
// rbc_in_reg
// Input register stage; takes a transaction whenever it is empty or the core moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_valid,
  output logic                   s_ready,
  input  wire rbc_pkg::in_item_t s_item,
  output rbc_pkg::stage_t        stage,
  input  wire logic              core_ready
);

  logic             valid;
  rbc_pkg::in_item_t item;

  assign s_ready     = !valid || core_ready;
  assign stage.valid = valid;
  assign stage.item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rbc_core.sv
// ----------------------------------------------------------------------------
// rbc_core
// Line/space state, per-byte decision and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_core #(
  parameter int BREAK_COUNT_BITS = rbc_pkg::BreakCountBitsDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rbc_pkg::stage_t     stage,
  output logic                     core_ready,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output rbc_pkg::out_item_t       m_item
);

  localparam int CmpW = (BREAK_COUNT_BITS > rbc_pkg::OutBreakBits) ?
                        BREAK_COUNT_BITS : rbc_pkg::OutBreakBits;

  logic [BREAK_COUNT_BITS-1:0] held_breaks, held_breaks_next;
  logic                        held_space, held_space_next;
  logic                        held_cr, held_cr_next;
  logic                        count_clipped, count_clipped_next;
  rbc_pkg::out_item_t          res_next;

  logic       take;
  logic [7:0] b;
  logic       present, last, is_lf, is_cr, is_wsp, flush, over;
  logic [CmpW-1:0] held_ext;

  assign core_ready = !m_valid || m_ready;
  assign take       = stage.valid && core_ready;

  assign b       = stage.item.in_byte;
  assign present = stage.item.byte_present;
  assign last    = stage.item.last_of_body;
  assign is_lf   = (b == rbc_pkg::ChLf);
  assign is_cr   = (b == rbc_pkg::ChCr);
  assign is_wsp  = (b == rbc_pkg::ChSp) || (b == rbc_pkg::ChTab);
  assign flush   = present && !is_lf && (held_cr || (!is_wsp && !is_cr));

  assign held_ext = CmpW'(held_breaks);
  assign over     = held_ext > CmpW'(rbc_pkg::OutBreakMax);

  always_comb begin
    held_breaks_next   = held_breaks;
    held_space_next    = held_space;
    held_cr_next       = held_cr;
    count_clipped_next = count_clipped;
    res_next           = '0;

    if (present && is_lf) begin
      held_space_next = 1'b0;
      held_cr_next    = 1'b0;
      if (held_breaks == '1) begin
        count_clipped_next = 1'b1;
      end else begin
        held_breaks_next = held_breaks + 1'b1;
      end
    end else if (present) begin
      if (flush) begin
        res_next.breaks_before  = over ? rbc_pkg::OutBreakMax
                                       : held_ext[rbc_pkg::OutBreakBits-1:0];
        res_next.breaks_clipped = over || count_clipped;
        res_next.space_before   = held_space;
        res_next.cr_before      = held_cr;
        held_breaks_next        = '0;
        count_clipped_next      = 1'b0;
        held_space_next         = 1'b0;
        held_cr_next            = 1'b0;
      end
      if (is_cr) begin
        held_cr_next = 1'b1;
      end else if (is_wsp) begin
        held_space_next = 1'b1;
      end else begin
        res_next.out_byte   = b;
        res_next.byte_valid = 1'b1;
      end
    end

    if (last) begin
      res_next.final_crlf = 1'b1;
      held_breaks_next    = '0;
      held_space_next     = 1'b0;
      held_cr_next        = 1'b0;
      count_clipped_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_breaks   <= '0;
      held_space    <= 1'b0;
      held_cr       <= 1'b0;
      count_clipped <= 1'b0;
      m_valid       <= 1'b0;
    end else begin
      if (take) begin
        held_breaks   <= held_breaks_next;
        held_space    <= held_space_next;
        held_cr       <= held_cr_next;
        count_clipped <= count_clipped_next;
      end
      if (core_ready) begin
        m_valid <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_item <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rbc_checker.sv
// ----------------------------------------------------------------------------
// rbc_checker
// Port-level checks of the canonicalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [7:0]  s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic s_take;
  logic flushed;

  assign s_take  = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'h00 || s_axis_tuser
                   || s_axis_tlast || 1'b1);
  assign flushed = (m_axis_tdata[15:0] != 16'h0) || m_axis_tdata[16] || m_axis_tdata[26];

  // Pending breaks or space only come out ahead of content or a bare CR.
  `RBC_ASSERT(a_flush_has_content, clk, rst,
    m_axis_tvalid && flushed |-> m_axis_tuser || m_axis_tdata[17])

  // No content byte means a zero byte field and zero padding.
  `RBC_ASSERT(a_idle_fields_zero, clk, rst,
    m_axis_tvalid |-> m_axis_tdata[31:27] == 5'h0 &&
    (m_axis_tuser || m_axis_tdata[25:18] == 8'h00))

  // A stalled result holds.
  `RBC_ASSERT(a_out_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // Nothing is offered right after reset.
  `RBC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid)

  // With no result offered, an accepted transaction shows up after the input and result registers.
  `RBC_ASSERT(a_take_yields, clk, rst,
    s_take && !m_axis_tvalid |=> ##1 m_axis_tvalid || $past(rst))

endmodule

bind relaxed_body_canonicalizer rbc_checker u_rbc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> sim/relaxed_body_canonicalizer_tb.sv
// ----------------------------------------------------------------------------
// relaxed_body_canonicalizer_tb
// Self-checking bench for the streaming relaxed body canonicalizer.
// ----------------------------------------------------------------------------
// Body bytes are queued up front: a directed run over whitespace, line ends,
// bare CR, idle steps and end-of-body, then random bodies with some noise and
// one long LF run that builds up a large held break count. A clocked driver
// streams them in with random gaps; a clocked monitor checks every output
// transaction against an in-bench model of the canonicalizer, with random
// backpressure and one long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module relaxed_body_canonicalizer_tb;

  localparam int          BreakBits    = rbc_pkg::BreakCountBitsDef;
  localparam int          WatchdogMax  = 2000;
  localparam int          RandomItems  = 1750;
  localparam int          LongRun      = 300;
  localparam int          HoldOffLen   = 250;
  localparam int          HoldOffAt    = 400;
  localparam longint unsigned BreakCap = (64'd1 << BreakBits) - 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        s_axis_tuser = 1'b0;    // [0] byte_present
  logic        s_axis_tlast = 1'b0;    // last_of_body
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [15:0] breaks_before, [16] space_before,
                                       // [17] cr_before, [25:18] out_byte,
                                       // [26] breaks_clipped
  logic        m_axis_tuser;           // [0] byte_valid
  logic        m_axis_tlast;           // final_crlf

  rbc_pkg::in_item_t  body_bytes[$];
  rbc_pkg::out_item_t canon_due[$];
  int unsigned     n_loaded = 0;
  int unsigned     n_sent = 0;
  int unsigned     n_results = 0;
  int unsigned     errors = 0;
  int unsigned     cyc = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     hold_left = 0;
  bit              held_off = 1'b0;
  logic            steady;

  // model state
  longint unsigned line_breaks = 0;
  bit              pend_space = 1'b0;
  bit              pend_cr = 1'b0;
  bit              breaks_sat = 1'b0;

  relaxed_body_canonicalizer #(
    .BREAK_COUNT_BITS(BreakBits)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  assign steady = (cyc >= 1500) && (cyc < 3000);

  function automatic rbc_pkg::out_item_t canon_step(rbc_pkg::in_item_t it);
    rbc_pkg::out_item_t r;
    bit        is_ws;
    r = '0;
    is_ws = (it.in_byte == rbc_pkg::ChSp) || (it.in_byte == rbc_pkg::ChTab);
    if (it.byte_present) begin
      if (it.in_byte == rbc_pkg::ChLf) begin
        pend_space = 1'b0;
        pend_cr = 1'b0;
        if (line_breaks >= BreakCap) begin
          line_breaks = BreakCap;
          breaks_sat = 1'b1;
        end else begin
          line_breaks++;
        end
      end else begin
        if (pend_cr || (!is_ws && it.in_byte != rbc_pkg::ChCr)) begin
          if (line_breaks > rbc_pkg::OutBreakMax) begin
            r.breaks_before = rbc_pkg::OutBreakMax;
            r.breaks_clipped = 1'b1;
          end else begin
            r.breaks_before = 16'(line_breaks);
          end
          if (breaks_sat) r.breaks_clipped = 1'b1;
          r.space_before = pend_space;
          r.cr_before = pend_cr;
          line_breaks = 0;
          breaks_sat = 1'b0;
          pend_space = 1'b0;
          pend_cr = 1'b0;
        end
        if (it.in_byte == rbc_pkg::ChCr) begin
          pend_cr = 1'b1;
        end else if (is_ws) begin
          pend_space = 1'b1;
        end else begin
          r.out_byte = it.in_byte;
          r.byte_valid = 1'b1;
        end
      end
    end
    if (it.last_of_body) begin
      r.final_crlf = 1'b1;
      line_breaks = 0;
      pend_space = 1'b0;
      pend_cr = 1'b0;
      breaks_sat = 1'b0;
    end
    return r;
  endfunction

  task automatic add_byte(logic [7:0] b, logic present, logic last);
    rbc_pkg::in_item_t it;
    it.in_byte = b;
    it.byte_present = present;
    it.last_of_body = last;
    body_bytes.push_back(it);
    n_loaded++;
  endtask

  // biased toward the bytes the canonicalizer treats specially
  function automatic logic [7:0] body_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return rbc_pkg::ChSp;
    if (r < 14) return rbc_pkg::ChTab;
    if (r < 22) return rbc_pkg::ChCr;
    if (r < 34) return rbc_pkg::ChLf;
    return 8'($urandom_range(255));
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (errors < 50)
      $display("mismatch on result %0d, %s: got %0h expected %0h", n_results, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    rbc_pkg::in_item_t cur;
    rbc_pkg::in_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cur.in_byte = s_axis_tdata;
        cur.byte_present = s_axis_tuser;
        cur.last_of_body = s_axis_tlast;
        canon_due.push_back(canon_step(cur));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (body_bytes.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
          nxt = body_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.in_byte;
          s_axis_tuser  <= nxt.byte_present;
          s_axis_tlast  <= nxt.last_of_body;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_proc
    rbc_pkg::out_item_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (canon_due.size() == 0) begin
          report_mismatch("unexpected transaction", m_axis_tdata, 0);
        end else begin
          want = canon_due.pop_front();
          if (m_axis_tdata[15:0] != want.breaks_before)
            report_mismatch("breaks_before", m_axis_tdata[15:0], want.breaks_before);
          if (m_axis_tdata[16] != want.space_before)
            report_mismatch("space_before", m_axis_tdata[16], want.space_before);
          if (m_axis_tdata[17] != want.cr_before)
            report_mismatch("cr_before", m_axis_tdata[17], want.cr_before);
          if (m_axis_tdata[25:18] != want.out_byte)
            report_mismatch("out_byte", m_axis_tdata[25:18], want.out_byte);
          if (m_axis_tuser != want.byte_valid)
            report_mismatch("byte_valid", m_axis_tuser, want.byte_valid);
          if (m_axis_tlast != want.final_crlf)
            report_mismatch("final_crlf", m_axis_tlast, want.final_crlf);
          if (m_axis_tdata[26] != want.breaks_clipped)
            report_mismatch("breaks_clipped", m_axis_tdata[26], want.breaks_clipped);
        end
        n_results++;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (n_results >= HoldOffAt && !held_off) begin
        held_off = 1'b1;
        hold_left = HoldOffLen;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogMax) begin
        $display("FAIL relaxed_body_canonicalizer");
        $finish;
      end
    end
  end

  initial begin : stim_proc
    int unsigned base;
    int unsigned len;
    bit          long_done;
    long_done = 1'b0;

    // directed
    add_byte(8'hA5, 1'b0, 1'b1);   // empty body
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(rbc_pkg::ChSp,  1'b1, 1'b0);
    add_byte(rbc_pkg::ChTab, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);   // collapsed space flushed
    add_byte(rbc_pkg::ChTab, 1'b1, 1'b0);
    add_byte(rbc_pkg::ChCr,  1'b1, 1'b0);
    add_byte(rbc_pkg::ChLf,  1'b1, 1'b0);   // CRLF drops the space
    add_byte(rbc_pkg::ChLf,  1'b1, 1'b0);
    add_byte(rbc_pkg::ChCr,  1'b1, 1'b0);
    add_byte(rbc_pkg::ChCr,  1'b1, 1'b0);   // first CR is bare
    add_byte(8'h41, 1'b1, 1'b0);
    add_byte(8'h5A, 1'b0, 1'b0);   // idle step
    add_byte(rbc_pkg::ChSp,  1'b1, 1'b0);
    add_byte(rbc_pkg::ChCr,  1'b1, 1'b1);   // held space and CR dropped at end
    add_byte(rbc_pkg::ChLf,  1'b1, 1'b1);
    add_byte(8'h7F, 1'b1, 1'b1);
    add_byte(rbc_pkg::ChLf,  1'b1, 1'b0);
    add_byte(rbc_pkg::ChSp,  1'b1, 1'b0);
    add_byte(rbc_pkg::ChCr,  1'b1, 1'b0);
    add_byte(rbc_pkg::ChSp,  1'b1, 1'b0);   // bare CR followed by whitespace
    add_byte(8'h80, 1'b1, 1'b1);

    // random bodies
    base = n_loaded;
    while (n_loaded - base < RandomItems) begin
      if (!long_done && n_loaded - base > RandomItems / 2) begin
        long_done = 1'b1;
        for (int i = 0; i < LongRun; i++) add_byte(rbc_pkg::ChLf, 1'b1, 1'b0);
        add_byte(8'h61, 1'b1, 1'b0);
        add_byte(rbc_pkg::ChSp, 1'b1, 1'b0);
        add_byte(8'h63, 1'b1, 1'b1);
      end
      if ($urandom_range(9) == 0) begin
        add_byte(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom_range(7) == 0);
      end else begin
        len = $urandom_range(30, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19) == 0) add_byte(8'($urandom_range(255)), 1'b0, 1'b0);
          else add_byte(body_byte(), 1'b1, 1'b0);
        end
        if ($urandom_range(1)) add_byte(body_byte(), 1'b1, 1'b1);
        else add_byte(8'($urandom_range(255)), 1'b0, 1'b1);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (n_sent != n_loaded || canon_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (canon_due.size() != 0) report_mismatch("results missing", canon_due.size(), 0);
    if (errors == 0) begin
      $display("PASS relaxed_body_canonicalizer");
    end else begin
      $display("FAIL relaxed_body_canonicalizer");
    end
    $finish;
  end

endmodule

`default_nettype wire
